// ===== rtl/gcdts_pkg.sv =====
`timescale 1ns / 1ps

package gcdts_pkg;

  // Default grid side; rows and columns both use it
  localparam int DEFAULT_GRID_SIDE = 16;

  // Fixed port widths
  localparam int GATE_W = 16;
  localparam int ADDR_W = 4;

  // Item codes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Bit positions in the packed level vector
  localparam int LVL_CLOCK  = 0;
  localparam int LVL_RESET  = 1;
  localparam int LVL_ROTATE = 2;
  localparam int LVL_SHIFT  = 3;
  localparam int LVL_CLEAR  = 4;
  localparam int LVL_W      = 5;

  // One result beat
  typedef struct packed {
    logic [GATE_W-1:0] or_gates;
    logic [GATE_W-1:0] xor_gates;
    logic              cell_before;
  } result_t;

endpackage

// ===== rtl/gcdts_core.sv =====
`timescale 1ns / 1ps

module gcdts_core #(
  parameter int GRID_SIDE = gcdts_pkg::DEFAULT_GRID_SIDE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          op,
  input  logic [gcdts_pkg::ADDR_W-1:0]  cell_col,
  input  logic [gcdts_pkg::ADDR_W-1:0]  cell_row,
  input  logic                          cell_value,
  input  logic                          clock_level,
  input  logic                          reset_level,
  input  logic                          rotate_level,
  input  logic                          shift_level,
  input  logic                          clear_level,
  output gcdts_pkg::result_t            result
);

  localparam int IW = $clog2(GRID_SIDE);

  // State
  logic [GRID_SIDE-1:0]        grid [GRID_SIDE];
  logic [IW-1:0]               divider_counts [GRID_SIDE];
  logic [IW-1:0]               scan_row;
  logic                        reset_armed;
  logic [gcdts_pkg::LVL_W-1:0] previous_levels;
  logic [GRID_SIDE-1:0]        or_hold;
  logic [GRID_SIDE-1:0]        xor_hold;

  // Next values
  logic [GRID_SIDE-1:0]        grid_next [GRID_SIDE];
  logic [IW-1:0]               divider_counts_next [GRID_SIDE];
  logic [IW-1:0]               scan_row_next;
  logic                        reset_armed_next;
  logic [gcdts_pkg::LVL_W-1:0] previous_levels_next;
  logic [GRID_SIDE-1:0]        or_hold_next;
  logic [GRID_SIDE-1:0]        xor_hold_next;

  // Tick datapath intermediates
  logic [gcdts_pkg::LVL_W-1:0] levels;
  logic [gcdts_pkg::LVL_W-1:0] rise;
  logic [GRID_SIDE-1:0]        g_clr [GRID_SIDE];
  logic [GRID_SIDE-1:0]        g_rot [GRID_SIDE];
  logic [GRID_SIDE-1:0]        g_sh  [GRID_SIDE];
  logic [IW-1:0]               cnt_tick [GRID_SIDE];
  logic                        armed_mid;
  logic [GRID_SIDE-1:0]        scan_bits;
  logic [GRID_SIDE-1:0]        fire;
  logic [IW-1:0]               gate_idx;
  logic                        one_fire;

  // Write addressing
  logic          addr_ok;
  logic [IW-1:0] wr_row;
  logic [IW-1:0] wr_col;
  logic          cell_before;

  assign addr_ok = (int'(cell_col) < GRID_SIDE) && (int'(cell_row) < GRID_SIDE);
  assign wr_row  = IW'(cell_row);
  assign wr_col  = IW'(cell_col);
  assign cell_before = addr_ok ? grid[wr_row][wr_col] : 1'b0;

  assign levels = {clear_level, shift_level, rotate_level, reset_level, clock_level};
  assign rise   = levels & ~previous_levels;

  // Grid actions in order: clear, rotate clockwise, roll rows up
  always_comb begin
    for (int r = 0; r < GRID_SIDE; r++) begin
      g_clr[r] = rise[gcdts_pkg::LVL_CLEAR] ? '0 : grid[r];
    end
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        g_rot[r][c] = rise[gcdts_pkg::LVL_ROTATE] ? g_clr[GRID_SIDE-1-c][r] : g_clr[r][c];
      end
    end
    for (int r = 0; r < GRID_SIDE; r++) begin
      if (rise[gcdts_pkg::LVL_SHIFT]) begin
        g_sh[r] = (r == GRID_SIDE - 1) ? g_rot[0] : g_rot[r+1];
      end else begin
        g_sh[r] = g_rot[r];
      end
    end
  end

  // Dividers: optional counter reset, then advance on a clock rise
  assign armed_mid = reset_armed | rise[gcdts_pkg::LVL_RESET];

  always_comb begin
    logic [IW-1:0] base;
    for (int x = 0; x < GRID_SIDE; x++) begin
      base = (rise[gcdts_pkg::LVL_CLOCK] && armed_mid) ? '0 : divider_counts[x];
      if (rise[gcdts_pkg::LVL_CLOCK]) begin
        cnt_tick[x] = (base == IW'(x)) ? '0 : base + 1'b1;
      end else begin
        cnt_tick[x] = divider_counts[x];
      end
    end
  end

  // Row scan: firing cells update this row's gate bits
  assign scan_bits = g_sh[scan_row];
  assign gate_idx  = IW'(GRID_SIDE - 1) - scan_row;

  always_comb begin
    for (int x = 0; x < GRID_SIDE; x++) begin
      fire[x] = scan_bits[x] && (cnt_tick[x] == '0);
    end
  end

  assign one_fire = (|fire) && ((fire & (fire - 1'b1)) == '0);

  // Next state selection
  always_comb begin
    grid_next            = grid;
    divider_counts_next  = divider_counts;
    scan_row_next        = scan_row;
    reset_armed_next     = reset_armed;
    previous_levels_next = previous_levels;
    or_hold_next         = or_hold;
    xor_hold_next        = xor_hold;
    if (op == gcdts_pkg::OP_WRITE) begin
      if (addr_ok) begin
        grid_next[wr_row][wr_col] = cell_value;
      end
    end else begin
      grid_next            = g_sh;
      divider_counts_next  = cnt_tick;
      previous_levels_next = levels;
      reset_armed_next     = rise[gcdts_pkg::LVL_CLOCK] ? 1'b0 : armed_mid;
      scan_row_next        = (scan_row == IW'(GRID_SIDE - 1)) ? '0 : scan_row + 1'b1;
      if (|fire) begin
        or_hold_next[gate_idx] = clock_level;
      end
      if (one_fire) begin
        xor_hold_next[gate_idx] = clock_level;
      end
    end
  end

  // Result beat for the item being accepted
  assign result.or_gates    = gcdts_pkg::GATE_W'(or_hold_next);
  assign result.xor_gates   = gcdts_pkg::GATE_W'(xor_hold_next);
  assign result.cell_before = cell_before;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GRID_SIDE; r++) begin
        grid[r]           <= '0;
        divider_counts[r] <= '0;
      end
      scan_row        <= '0;
      reset_armed     <= 1'b1;
      previous_levels <= '0;
      or_hold         <= '0;
      xor_hold        <= '0;
    end else if (accept) begin
      grid            <= grid_next;
      divider_counts  <= divider_counts_next;
      scan_row        <= scan_row_next;
      reset_armed     <= reset_armed_next;
      previous_levels <= previous_levels_next;
      or_hold         <= or_hold_next;
      xor_hold        <= xor_hold_next;
    end
  end

`ifndef SYNTHESIS
  // A clock rise always consumes the armed counter reset
  a_armed_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (op == gcdts_pkg::OP_TICK) && rise[gcdts_pkg::LVL_CLOCK] |=> !reset_armed)
    else $error("reset_armed still set after clock rise");

  // Write beats leave the scan position and edge history alone
  a_write_holds: assert property (@(posedge clk) disable iff (rst)
    accept && (op == gcdts_pkg::OP_WRITE) |=> $stable(scan_row) && $stable(previous_levels))
    else $error("write beat disturbed tick state");

  // Tick beats advance the scan row by one, wrapping at the grid side
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    accept && (op == gcdts_pkg::OP_TICK) |=>
      (($past(scan_row) == IW'(GRID_SIDE - 1)) ? (scan_row == '0)
                                                : (scan_row == $past(scan_row) + 1'b1)))
    else $error("scan row did not advance");

  // Column zero divides by one, so its counter stays at zero
  a_col0_zero: assert property (@(posedge clk) disable iff (rst)
    divider_counts[0] == '0)
    else $error("column zero counter left zero");
`endif

endmodule

// ===== rtl/grid_clock_divider_trigger_sequencer.sv =====
`timescale 1ns / 1ps

// Grid clock divider and trigger sequencer.
// Input channel (in_valid / in_stall) carries one beat per item: a sample tick
// (op = tick) with the five thresholded levels, or a grid cell write
// (op = write) with cell_col, cell_row and cell_value. Each accepted beat gives
// exactly one output beat (out_valid / out_stall) carrying the held OR and XOR
// gate vectors and the addressed cell as it was before the item.
// The result is registered in the output register, or in the skid register
// while the output is held. Throughput: one item per cycle while in_stall is
// low; grid clear, rotate and roll, divider update and the single row scan
// are done in the cycle the item is accepted, straight from the state registers.
// When the receiver stalls, the result waits in the output register and one
// further beat is taken into a skid register; in_stall rises only while the
// skid register is occupied, so at most two results wait.
// Reset clears the grid, divider counters, scan row, level history and held gate
// vectors, arms the counter reset for the first clock rise, and empties both
// output registers.

module grid_clock_divider_trigger_sequencer #(
  parameter int GRID_SIDE = gcdts_pkg::DEFAULT_GRID_SIDE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [gcdts_pkg::ADDR_W-1:0]  cell_col,
  input  logic [gcdts_pkg::ADDR_W-1:0]  cell_row,
  input  logic                          cell_value,
  input  logic                          clock_level,
  input  logic                          reset_level,
  input  logic                          rotate_level,
  input  logic                          shift_level,
  input  logic                          clear_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcdts_pkg::GATE_W-1:0]  or_gates,
  output logic [gcdts_pkg::GATE_W-1:0]  xor_gates,
  output logic                          cell_before
);

  logic               accept;
  gcdts_pkg::result_t result;
  gcdts_pkg::result_t out_reg;
  gcdts_pkg::result_t skid_reg;
  logic               skid_valid;
  logic               out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  gcdts_core #(
    .GRID_SIDE (GRID_SIDE)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (op),
    .cell_col     (cell_col),
    .cell_row     (cell_row),
    .cell_value   (cell_value),
    .clock_level  (clock_level),
    .reset_level  (reset_level),
    .rotate_level (rotate_level),
    .shift_level  (shift_level),
    .clear_level  (clear_level),
    .result       (result)
  );

  // Output register with one skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_reg   <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_reg   <= result;
      skid_valid <= 1'b1;
    end
  end

  assign or_gates    = out_reg.or_gates;
  assign xor_gates   = out_reg.xor_gates;
  assign cell_before = out_reg.cell_before;

`ifndef SYNTHESIS
  // Skid stage is only used behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat without output beat");

  // After an accepted beat, out_valid is high in the next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat lost");

  // A held output beat with a full skid blocks the input
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && accept |=> in_stall)
    else $error("second waiting beat not stalling input");
`endif

endmodule

// ===== tb/sv/tb_grid_clock_divider_trigger_sequencer.sv =====
`timescale 1ns / 1ps

module tb_grid_clock_divider_trigger_sequencer;

  localparam int SIDE       = gcdts_pkg::DEFAULT_GRID_SIDE;
  localparam int ADDR_W     = gcdts_pkg::ADDR_W;
  localparam int GATE_W     = gcdts_pkg::GATE_W;
  localparam int LVL_W      = gcdts_pkg::LVL_W;
  localparam int LVL_CLOCK  = gcdts_pkg::LVL_CLOCK;
  localparam int LVL_RESET  = gcdts_pkg::LVL_RESET;
  localparam int LVL_ROTATE = gcdts_pkg::LVL_ROTATE;
  localparam int LVL_SHIFT  = gcdts_pkg::LVL_SHIFT;
  localparam int LVL_CLEAR  = gcdts_pkg::LVL_CLEAR;

  typedef gcdts_pkg::op_t     op_t;
  typedef gcdts_pkg::result_t result_t;

  localparam op_t OP_TICK  = gcdts_pkg::OP_TICK;
  localparam op_t OP_WRITE = gcdts_pkg::OP_WRITE;

  // Single-level masks for building tick beats
  localparam logic [LVL_W-1:0] L_CLK = LVL_W'(1 << LVL_CLOCK);
  localparam logic [LVL_W-1:0] L_RST = LVL_W'(1 << LVL_RESET);
  localparam logic [LVL_W-1:0] L_ROT = LVL_W'(1 << LVL_ROTATE);
  localparam logic [LVL_W-1:0] L_SHF = LVL_W'(1 << LVL_SHIFT);
  localparam logic [LVL_W-1:0] L_CLR = LVL_W'(1 << LVL_CLEAR);

  // One input beat as the sender drives it
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] row;
    logic              value;
    logic [LVL_W-1:0]  levels;
  } beat_t;

  // Grid/divider predictor plus the queue of gate results still owed
  class gate_scoreboard;
    bit                grid [SIDE][SIDE];
    int unsigned       div_count [SIDE];
    int unsigned       scan_row;
    bit                reset_armed;
    logic [LVL_W-1:0]  last_levels;
    logic [GATE_W-1:0] or_hold;
    logic [GATE_W-1:0] xor_hold;
    result_t           owed_q[$];
    int unsigned       errors;

    function new();
      foreach (grid[r, c]) grid[r][c] = 0;
      foreach (div_count[x]) div_count[x] = 0;
      scan_row    = 0;
      reset_armed = 1;
      last_levels = '0;
      or_hold     = '0;
      xor_hold    = '0;
      errors      = 0;
    endfunction

    // Advance the model by one accepted beat and queue its result
    function void note_beat(beat_t b);
      bit               moved [SIDE][SIDE];
      logic [LVL_W-1:0] rise;
      logic             clk_lvl;
      int unsigned      firing;
      int unsigned      n;
      result_t          res;

      res.cell_before = grid[b.row][b.col];
      if (b.op == OP_WRITE) begin
        grid[b.row][b.col] = b.value;
      end else begin
        rise        = b.levels & ~last_levels;
        last_levels = b.levels;
        clk_lvl     = b.levels[LVL_CLOCK];
        firing      = 0;

        // triggers act in order: clear, reset arm, rotate, shift
        if (rise[LVL_CLEAR]) begin
          foreach (grid[r, c]) grid[r][c] = 0;
        end
        if (rise[LVL_RESET]) reset_armed = 1;
        if (rise[LVL_ROTATE]) begin
          foreach (moved[r, c]) moved[r][c] = grid[SIDE-1-c][r];
          grid = moved;
        end
        if (rise[LVL_SHIFT]) begin
          foreach (moved[r, c]) moved[r][c] = grid[(r+1) % SIDE][c];
          grid = moved;
        end

        // dividers move on clock rise; an armed reset zeroes them first
        if (rise[LVL_CLOCK]) begin
          if (reset_armed) begin
            reset_armed = 0;
            foreach (div_count[x]) div_count[x] = 0;
          end
          foreach (div_count[x]) begin
            n = div_count[x] + 1;
            div_count[x] = (n > x) ? 0 : n;
          end
        end

        // scan one row
        for (int x = 0; x < SIDE; x++) begin
          if (grid[scan_row][x] && div_count[x] == 0) begin
            or_hold[SIDE-1-scan_row] = clk_lvl;
            firing++;
          end
        end
        if (firing == 1) xor_hold[SIDE-1-scan_row] = clk_lvl;
        scan_row = (scan_row + 1) % SIDE;
      end

      res.or_gates  = or_hold;
      res.xor_gates = xor_hold;
      owed_q.push_back(res);
    endfunction

    // Compare an output beat with the oldest owed result
    function void check_result(result_t got);
      result_t want;

      if (owed_q.size() == 0) begin
        $error("output beat with nothing owed: or_gates %h xor_gates %h cell_before %b",
               got.or_gates, got.xor_gates, got.cell_before);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.or_gates !== want.or_gates) begin
        $error("or_gates: expected %h, got %h", want.or_gates, got.or_gates);
        errors++;
      end
      if (got.xor_gates !== want.xor_gates) begin
        $error("xor_gates: expected %h, got %h", want.xor_gates, got.xor_gates);
        errors++;
      end
      if (got.cell_before !== want.cell_before) begin
        $error("cell_before: expected %b, got %b", want.cell_before, got.cell_before);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic [ADDR_W-1:0] cell_col;
  logic [ADDR_W-1:0] cell_row;
  logic              cell_value;
  logic              clock_level;
  logic              reset_level;
  logic              rotate_level;
  logic              shift_level;
  logic              clear_level;
  logic              out_valid;
  logic              out_stall;
  logic [GATE_W-1:0] or_gates;
  logic [GATE_W-1:0] xor_gates;
  logic              cell_before;

  gate_scoreboard sb = new();
  bit             calm = 0;

  grid_clock_divider_trigger_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .cell_col     (cell_col),
    .cell_row     (cell_row),
    .cell_value   (cell_value),
    .clock_level  (clock_level),
    .reset_level  (reset_level),
    .rotate_level (rotate_level),
    .shift_level  (shift_level),
    .clear_level  (clear_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .or_gates     (or_gates),
    .xor_gates    (xor_gates),
    .cell_before  (cell_before)
  );

  always #1 clk = ~clk;

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic beat_t mk(op_t o, int unsigned col, int unsigned row,
                               int unsigned value, logic [LVL_W-1:0] levels);
    beat_t b;
    b.op     = o;
    b.col    = ADDR_W'(col);
    b.row    = ADDR_W'(row);
    b.value  = 1'(value);
    b.levels = levels;
    return b;
  endfunction

  // Drive one beat after an optional gap, hold it until accepted
  task automatic send_beat(input beat_t b);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    op           = b.op;
    cell_col     = b.col;
    cell_row     = b.row;
    cell_value   = b.value;
    clock_level  = b.levels[LVL_CLOCK];
    reset_level  = b.levels[LVL_RESET];
    rotate_level = b.levels[LVL_ROTATE];
    shift_level  = b.levels[LVL_SHIFT];
    clear_level  = b.levels[LVL_CLEAR];
    in_valid     = 1;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
  endtask

  // Receiver stall pattern
  initial begin : stall_gen
    int unsigned hold;
    out_stall = 0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (calm || $urandom_range(0, 99) >= 35) begin
        out_stall = 0;
        hold      = $urandom_range(1, 6);
      end else begin
        out_stall = 1;
        hold      = idle_len();
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin : out_mon
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.or_gates    = or_gates;
      got.xor_gates   = xor_gates;
      got.cell_before = cell_before;
      sb.check_result(got);
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus
  initial begin : stim
    beat_t            b;
    logic [LVL_W-1:0] lv;

    rst          = 1;
    in_valid     = 0;
    op           = OP_TICK;
    cell_col     = '0;
    cell_row     = '0;
    cell_value   = 0;
    clock_level  = 0;
    reset_level  = 0;
    rotate_level = 0;
    shift_level  = 0;
    clear_level  = 0;
    repeat (8) @(negedge clk);
    rst = 0;

    // directed: corner cells, readback, every trigger, clear
    send_beat(mk(OP_TICK,  0,  0, 0, '0));
    send_beat(mk(OP_WRITE, 0,  0, 1, '0));
    send_beat(mk(OP_WRITE, 15, 15, 1, '0));
    send_beat(mk(OP_WRITE, 15, 0, 1, '0));
    send_beat(mk(OP_WRITE, 0,  15, 1, '0));
    send_beat(mk(OP_WRITE, 0,  0, 1, '1));
    send_beat(mk(OP_WRITE, 7,  3, 1, '0));
    send_beat(mk(OP_TICK,  15, 15, 1, L_CLK));
    send_beat(mk(OP_TICK,  0,  0, 0, '0));
    send_beat(mk(OP_TICK,  7,  3, 1, L_CLK));
    send_beat(mk(OP_TICK,  0,  0, 0, '0));
    send_beat(mk(OP_TICK,  0,  0, 0, L_CLK | L_RST));
    send_beat(mk(OP_TICK,  0,  0, 0, '0));
    send_beat(mk(OP_TICK,  0,  0, 0, L_CLK | L_RST));
    send_beat(mk(OP_TICK,  15, 0, 0, L_ROT));
    send_beat(mk(OP_TICK,  0,  0, 0, '0));
    send_beat(mk(OP_TICK,  15, 15, 0, L_SHF));
    send_beat(mk(OP_TICK,  0,  15, 0, '0));
    send_beat(mk(OP_TICK,  0,  0, 1, L_CLK | L_RST | L_ROT | L_SHF | L_CLR));
    send_beat(mk(OP_TICK,  0,  0, 0, '0));
    send_beat(mk(OP_WRITE, 15, 15, 0, '0));
    send_beat(mk(OP_WRITE, 15, 15, 1, '0));

    // random: mostly sparse trigger activity over a filling grid
    lv = '0;
    for (int i = 0; i < 1030; i++) begin
      calm     = (i >= 400 && i < 550);
      b.col    = ADDR_W'($urandom_range(0, 15));
      b.row    = ADDR_W'($urandom_range(0, 15));
      b.value  = ($urandom_range(0, 99) < 75);
      if ($urandom_range(0, 99) < 30) begin
        b.op     = OP_WRITE;
        b.levels = LVL_W'($urandom);
      end else begin
        b.op = OP_TICK;
        if ($urandom_range(0, 99) < 60) lv ^= L_CLK;
        if ($urandom_range(0, 99) < 10) lv ^= L_RST;
        if ($urandom_range(0, 99) < 8)  lv ^= L_ROT;
        if ($urandom_range(0, 99) < 10) lv ^= L_SHF;
        if ($urandom_range(0, 99) < 3)  lv ^= L_CLR;
        b.levels = lv;
      end
      send_beat(b);
    end
    calm = 0;

    @(negedge clk);
    in_valid = 0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
